@@ sv/ssp_pkg.sv @@
// Shared types, constants and helpers for the Shell sort pair-key core.
// Depends on nothing; every module of the core imports it.
package ssp_pkg;

    // Capacity of the record store and derived widths.
    localparam int MAX_ITEMS   = 64;
    localparam int WORD_W      = 32;
    localparam int KEY_W       = 2 * WORD_W;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    // The largest gap used is below three times the capacity.
    localparam int GAP_W       = $clog2(3 * MAX_ITEMS);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Flipping the sign bit of each word turns the signed lexicographic
    // order into a plain unsigned compare of the packed key.
    localparam logic [WORD_W-1:0] SIGN_BIAS = {1'b1, {(WORD_W - 1){1'b0}}};

    // One queued record, key already biased.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } t_item;

    // Next Knuth gap: 3 * g + 1, kept two bits wider than the gap.
    function automatic logic [GAP_W+1:0] gap_next(input logic [GAP_W-1:0] g);
        return ({2'b00, g} << 1) + {2'b00, g} + (GAP_W + 2)'(1);
    endfunction

endpackage

@@ sv/shell_sort_pair_keys_core.sv @@
// Batch sorter of signed word pairs by Shell sort with Knuth gaps.
// Loading accepts one word per cycle; a four-entry queue absorbs words while the back is busy.
// Sort: gapped insertion passes over the record store, which has one write and one registered read port.
// Emit: each record is read from the store and then loaded into the result register.
// Reset (synchronous, active low) empties the queue, the batch count and the result register.
module shell_sort_pair_keys_core import ssp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic signed [WORD_W-1:0] i_key_high,
    input  logic signed [WORD_W-1:0] i_key_low,
    input  logic                     i_is_last,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic signed [WORD_W-1:0] o_out_high,
    output logic signed [WORD_W-1:0] o_out_low,
    output logic                     o_out_last,
    output logic                     o_overflowed
);

    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    // Front: input word handshake and queue.
    ssp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_key_high (i_key_high),
        .i_key_low  (i_key_low),
        .i_is_last  (i_is_last),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    // Back: store, sort and emit.
    ssp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_out_high   (o_out_high),
        .o_out_low    (o_out_low),
        .o_out_last   (o_out_last),
        .o_overflowed (o_overflowed)
    );

    // The back never takes a word from an empty queue.
    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back popped an empty queue");

    // A full queue always offers a word to the back.
    a_full_offers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> q_valid)
        else $error("queue full but no word offered");

    // An accepted input word is visible to the back on the next cycle.
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> q_valid)
        else $error("accepted word not queued");

endmodule

@@ sv/ssp_front.sv @@
// Front of the sort core: takes input words, biases the keys and queues them.
// Depends on ssp_pkg for the item type and the queue depth.
module ssp_front import ssp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic signed [WORD_W-1:0] i_key_high,
    input  logic signed [WORD_W-1:0] i_key_low,
    input  logic                     i_is_last,
    output logic                     o_q_valid,
    output t_item                    o_q_item,
    input  logic                     i_q_pop
);

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_level;
    logic              push_ok;
    logic              pop_ok;
    t_item             in_item;

    // Handshakes on both sides of the queue.
    assign o_full    = (r_level == QCNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_level != '0);
    assign push_ok   = i_push && !o_full;
    assign pop_ok    = i_q_pop && o_q_valid;

    // Pack the incoming word: both halves with flipped sign bits.
    assign in_item.key  = {i_key_high ^ SIGN_BIAS, i_key_low ^ SIGN_BIAS};
    assign in_item.last = i_is_last;

    assign o_q_item = r_q[r_rd];

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= in_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_level <= r_level + QCNT_W'(1);
                2'b01:   r_level <= r_level - QCNT_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

@@ sv/ssp_back.sv @@
// Back of the sort core: stores a batch, runs Shell sort with Knuth gaps
// and emits the sorted records. Depends on ssp_pkg.
module ssp_back import ssp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    input  t_item                    i_q_item,
    output logic                     o_q_pop,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic signed [WORD_W-1:0] o_out_high,
    output logic signed [WORD_W-1:0] o_out_low,
    output logic                     o_out_last,
    output logic                     o_overflowed
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_GAP_UP,
        S_OUT_RD,
        S_HELD,
        S_INNER,
        S_CMP,
        S_GAP_DN,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [GAP_W-1:0]   r_gap;
    logic [GAP_W-1:0]   r_scan;
    logic [GAP_W-1:0]   r_i;
    logic [GAP_W-1:0]   r_j;
    logic [KEY_W-1:0]   r_held;
    logic [ADDR_W-1:0]  r_k;
    logic               r_out_valid;
    logic [KEY_W-1:0]   r_out_rec;
    logic               r_out_last;
    logic               r_out_ovf;

    logic [KEY_W-1:0]   r_store [MAX_ITEMS];
    logic [KEY_W-1:0]   r_rd_data;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [KEY_W-1:0]   mem_wd;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_ra;

    logic [GAP_W-1:0]   j_dn;
    logic [GAP_W+1:0]   gap_up;
    logic [GAP_W+1:0]   scan_up;
    logic               held_le;
    logic               out_pop;
    logic               out_free;
    logic               emit_load;
    logic               k_last;
    logic               room;

    // Helper values shared by the sequencer and the memory controls.
    assign j_dn      = r_j - r_gap;
    assign gap_up    = gap_next(r_gap);
    assign scan_up   = gap_next(r_scan);
    assign held_le   = (r_held <= r_rd_data);
    assign out_pop   = i_pop && r_out_valid;
    assign out_free  = !r_out_valid || out_pop;
    assign emit_load = (r_state == S_EMIT_WR) && out_free;
    assign k_last    = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
    assign room      = (r_count < CNT_W'(MAX_ITEMS));

    // Result register drives the output ports; keys are unbiased here.
    assign o_empty      = !r_out_valid;
    assign o_out_high   = $signed(r_out_rec[KEY_W-1:WORD_W] ^ SIGN_BIAS);
    assign o_out_low    = $signed(r_out_rec[WORD_W-1:0] ^ SIGN_BIAS);
    assign o_out_last   = r_out_last;
    assign o_overflowed = r_out_ovf;

    // Memory port controls for each step of the sequencer.
    always_comb begin
        o_q_pop = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = r_held;
        mem_re  = 1'b0;
        mem_ra  = '0;
        unique case (r_state)
            S_LOAD: begin
                o_q_pop = i_q_valid;
                if (i_q_valid && room) begin
                    mem_we = 1'b1;
                    mem_wa = r_count[ADDR_W-1:0];
                    mem_wd = i_q_item.key;
                end
            end
            S_OUT_RD: begin
                if (r_i < GAP_W'(r_count)) begin
                    mem_re = 1'b1;
                    mem_ra = r_i[ADDR_W-1:0];
                end
            end
            S_INNER: begin
                if (r_j >= r_gap) begin
                    mem_re = 1'b1;
                    mem_ra = j_dn[ADDR_W-1:0];
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_j[ADDR_W-1:0];
                    mem_wd = r_held;
                end
            end
            S_CMP: begin
                mem_we = 1'b1;
                mem_wa = r_j[ADDR_W-1:0];
                mem_wd = held_le ? r_rd_data : r_held;
            end
            S_EMIT_RD: begin
                mem_re = 1'b1;
                mem_ra = r_k;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Record store with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_store[mem_ra];
        end
    end

    // Sequencer: load, climb the gaps, insertion passes, emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_gap       <= '0;
            r_scan      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_held      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_out_rec   <= '0;
            r_out_last  <= 1'b0;
            r_out_ovf   <= 1'b0;
        end else begin
            // The result register fills on an emit step and empties on a pop.
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_q_valid) begin
                        if (room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_q_item.last) begin
                            r_gap   <= GAP_W'(1);
                            r_state <= S_GAP_UP;
                        end
                    end
                end
                S_GAP_UP: begin
                    if (r_gap < GAP_W'(r_count)) begin
                        r_gap <= gap_up[GAP_W-1:0];
                    end else begin
                        r_i     <= r_gap;
                        r_state <= S_OUT_RD;
                    end
                end
                S_OUT_RD: begin
                    if (r_i < GAP_W'(r_count)) begin
                        r_j     <= r_i;
                        r_state <= S_HELD;
                    end else begin
                        r_scan  <= GAP_W'(1);
                        r_state <= S_GAP_DN;
                    end
                end
                S_HELD: begin
                    r_held  <= r_rd_data;
                    r_state <= S_INNER;
                end
                S_INNER: begin
                    if (r_j >= r_gap) begin
                        r_state <= S_CMP;
                    end else begin
                        r_i     <= r_i + GAP_W'(1);
                        r_state <= S_OUT_RD;
                    end
                end
                S_CMP: begin
                    if (held_le) begin
                        r_j     <= j_dn;
                        r_state <= S_INNER;
                    end else begin
                        r_i     <= r_i + GAP_W'(1);
                        r_state <= S_OUT_RD;
                    end
                end
                S_GAP_DN: begin
                    // Find the gap below the current one by climbing from 1.
                    if (r_gap == GAP_W'(1)) begin
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else if (scan_up == {2'b00, r_gap}) begin
                        r_gap   <= r_scan;
                        r_i     <= r_scan;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_scan <= scan_up[GAP_W-1:0];
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (out_free) begin
                        r_out_rec   <= r_rd_data;
                        r_out_last  <= k_last;
                        r_out_ovf   <= r_ovf;
                        if (k_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + ADDR_W'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/shell_sort_pair_keys_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for shell_sort_pair_keys_core: batches of signed word pairs in,
// sorted records out, each checked against a sorter written in the bench. Uses ssp_pkg.
module shell_sort_pair_keys_core_tb;
    import ssp_pkg::*;

    localparam logic [WORD_W-1:0] WORD_MAX    = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN    = 32'h8000_0000;
    localparam int                WORD_TARGET = 380;
    localparam int                STALL_LIMIT = 20000;
    localparam int                DRAIN_CYCLES = 200;

    // Key flavors for random words.
    localparam int MODE_FULL    = 0;
    localparam int MODE_NARROW  = 1;
    localparam int MODE_EXTREME = 2;

    // One sorted record as it leaves the block.
    typedef struct packed {
        logic [WORD_W-1:0] high;
        logic [WORD_W-1:0] low;
        logic              last;
        logic              ovf;
    } t_sorted_rec;

    // One directed word; rec holds the typed-in result where typed is set.
    typedef struct packed {
        logic [WORD_W-1:0] high;
        logic [WORD_W-1:0] low;
        logic              last;
        logic              typed;
        t_sorted_rec       rec;
    } t_stim_row;

    localparam t_sorted_rec NO_REC = '0;
    localparam int DIRECTED_ROWS = 19;

    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // Single-record batches right after reset, results read off directly.
        '{32'h0, 32'h0, 1'b1, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b0}},
        '{WORD_MAX, WORD_MIN, 1'b1, 1'b1, '{WORD_MAX, WORD_MIN, 1'b1, 1'b0}},
        '{WORD_MIN, WORD_MAX, 1'b1, 1'b1, '{WORD_MIN, WORD_MAX, 1'b1, 1'b0}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
          '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0}},
        // Equal high words with signed low words, a duplicate and both extremes.
        '{32'd5, -32'sd3, 1'b0, 1'b0, NO_REC},
        '{32'd5, 32'd7, 1'b0, 1'b0, NO_REC},
        '{32'd5, -32'sd3, 1'b0, 1'b0, NO_REC},
        '{-32'sd5, 32'd100, 1'b0, 1'b0, NO_REC},
        '{WORD_MIN, WORD_MIN, 1'b0, 1'b0, NO_REC},
        '{WORD_MAX, WORD_MAX, 1'b0, 1'b0, NO_REC},
        '{32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_REC},
        '{32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, NO_REC},
        // High word decides even when the low word disagrees.
        '{32'd1, 32'd0, 1'b0, 1'b0, NO_REC},
        '{32'd0, 32'd1, 1'b1, 1'b0, NO_REC},
        // Strictly descending batch.
        '{32'd3, 32'd0, 1'b0, 1'b0, NO_REC},
        '{32'd2, 32'd0, 1'b0, 1'b0, NO_REC},
        '{32'd1, 32'd0, 1'b0, 1'b0, NO_REC},
        '{32'd0, 32'd0, 1'b0, 1'b0, NO_REC},
        '{32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, NO_REC}
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_push = 1'b0;
    logic                     o_full;
    logic signed [WORD_W-1:0] i_key_high = '0;
    logic signed [WORD_W-1:0] i_key_low = '0;
    logic                     i_is_last = 1'b0;
    logic                     o_empty;
    logic                     i_pop = 1'b0;
    logic signed [WORD_W-1:0] o_out_high;
    logic signed [WORD_W-1:0] o_out_low;
    logic                     o_out_last;
    logic                     o_overflowed;

    shell_sort_pair_keys_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_key_high   (i_key_high),
        .i_key_low    (i_key_low),
        .i_is_last    (i_is_last),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_out_high   (o_out_high),
        .o_out_low    (o_out_low),
        .o_out_last   (o_out_last),
        .o_overflowed (o_overflowed)
    );

    // Sorter state mirrored in the bench; keys are stored sign-biased.
    logic [KEY_W-1:0] key_store [MAX_ITEMS];
    int               key_count = 0;
    bit               batch_dropped = 1'b0;
    t_sorted_rec      fresh_q [$];
    t_sorted_rec      sorted_q [$];

    int  error_count = 0;
    int  words_sent = 0;
    int  batches_sent = 0;
    int  overflow_batches = 0;
    int  records_checked = 0;
    int  quiet_cycles = 0;
    int  cycle_no = 0;
    bit  steady;

    // A long window in which neither side idles.
    assign steady = (cycle_no >= 3000) && (cycle_no < 7000);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Take one word; on a last mark, sort the batch and leave it in fresh_q.
    function automatic void sorter_take(input logic [WORD_W-1:0] h, l, input logic last);
        int               gap;
        int               i;
        int               j;
        logic [KEY_W-1:0] held;
        fresh_q.delete();
        if (key_count < MAX_ITEMS) begin
            key_store[key_count] = {h ^ SIGN_BIAS, l ^ SIGN_BIAS};
            key_count++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (!last) return;
        // First Knuth gap not below the count, then gapped insertion passes.
        gap = 1;
        while (gap < key_count) gap = 3 * gap + 1;
        while (gap > 0) begin
            for (i = gap; i < key_count; i++) begin
                held = key_store[i];
                j = i;
                while (j >= gap && held <= key_store[j - gap]) begin
                    key_store[j] = key_store[j - gap];
                    j -= gap;
                end
                key_store[j] = held;
            end
            gap /= 3;
        end
        for (i = 0; i < key_count; i++) begin
            fresh_q.push_back('{key_store[i][KEY_W-1:WORD_W] ^ SIGN_BIAS,
                                key_store[i][WORD_W-1:0] ^ SIGN_BIAS,
                                (i == key_count - 1), batch_dropped});
        end
        batches_sent++;
        if (batch_dropped) overflow_batches++;
        key_count = 0;
        batch_dropped = 1'b0;
    endfunction

    // Compare the word on the result ports with the oldest expected record.
    function automatic void check_record();
        t_sorted_rec want;
        if (sorted_q.size() == 0) begin
            $error("unexpected result: high %h low %h last %b overflowed %b",
                   o_out_high, o_out_low, o_out_last, o_overflowed);
            error_count++;
            return;
        end
        want = sorted_q.pop_front();
        records_checked++;
        if (o_out_high !== want.high) begin
            $error("out_high: expected %h, actual %h", want.high, o_out_high);
            error_count++;
        end
        if (o_out_low !== want.low) begin
            $error("out_low: expected %h, actual %h", want.low, o_out_low);
            error_count++;
        end
        if (o_out_last !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, o_out_last);
            error_count++;
        end
        if (o_overflowed !== want.ovf) begin
            $error("overflowed: expected %b, actual %b", want.ovf, o_overflowed);
            error_count++;
        end
    endfunction

    function automatic logic [WORD_W-1:0] rand_word(input int mode);
        case (mode)
            MODE_NARROW: return WORD_W'($urandom_range(4)) - WORD_W'(2);
            MODE_EXTREME: begin
                case ($urandom_range(3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Result side: pop with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            i_pop <= steady || ($urandom_range(99) >= 10);
        end
    end

    // Check popped results and watch for a stalled block.
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (i_rst_n) begin
            if (i_pop && !o_empty) check_record();
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one word, with random idle cycles in front, and wait until it is taken.
    task automatic send_word(input logic [WORD_W-1:0] h, l, input logic last,
                             input logic typed, input t_sorted_rec typed_rec);
        while (!steady && $urandom_range(99) < 10) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push     <= 1'b1;
        i_key_high <= h;
        i_key_low  <= l;
        i_is_last  <= last;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sorter_take(h, l, last);
        words_sent++;
        if (typed) begin
            sorted_q.push_back(typed_rec);
        end else begin
            foreach (fresh_q[k]) sorted_q.push_back(fresh_q[k]);
        end
    endtask

    // A batch of random records, the last one marked.
    task automatic send_batch(input int count);
        int hi_mode;
        int lo_mode;
        int k;
        hi_mode = $urandom_range(MODE_EXTREME, MODE_FULL);
        lo_mode = $urandom_range(MODE_EXTREME, MODE_FULL);
        for (k = 0; k < count; k++) begin
            send_word(rand_word(($urandom_range(3) == 0) ?
                                $urandom_range(MODE_EXTREME, MODE_FULL) : hi_mode),
                      rand_word(($urandom_range(3) == 0) ?
                                $urandom_range(MODE_EXTREME, MODE_FULL) : lo_mode),
                      (k == count - 1), 1'b0, NO_REC);
        end
    endtask

    // Hold the sender until every expected record has come out.
    task automatic drain_results();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (sorted_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int r;
        int count;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            send_word(DIRECTED[n].high, DIRECTED[n].low, DIRECTED[n].last,
                      DIRECTED[n].typed, DIRECTED[n].rec);
        end
        drain_results();

        // Exactly full, last mark on the first dropped word, and drops before the last.
        send_batch(MAX_ITEMS);
        send_batch(MAX_ITEMS + 1);
        send_batch(MAX_ITEMS + 6);

        // Random batches, mostly small, trimmed to end at the word target.
        while (words_sent < WORD_TARGET) begin
            r = $urandom_range(99);
            if (r < 70) count = $urandom_range(10, 1);
            else if (r < 90) count = $urandom_range(40, 11);
            else count = $urandom_range(MAX_ITEMS + 8, MAX_ITEMS - 4);
            if (count > WORD_TARGET - words_sent) count = WORD_TARGET - words_sent;
            send_batch(count);
            if ($urandom_range(7) == 0) drain_results();
        end
        i_push <= 1'b0;

        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words in %0d batches (%0d with dropped records).",
                 words_sent, batches_sent, overflow_batches);
        $display("Checked %0d sorted records against the bench sorter.", records_checked);
        if (error_count == 0 && sorted_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ssp_pkg.sv
sv/ssp_front.sv
sv/ssp_back.sv
sv/shell_sort_pair_keys_core.sv
tb/sv/shell_sort_pair_keys_core_tb.sv
